[src/met_pkg.sv]
package met_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int INDEX_BITS = 16;
  localparam int VAL_BITS   = FRAC_BITS + 4;
  localparam int PROD_BITS  = 2 * VAL_BITS;
  localparam int CNT_BITS   = 16;
  localparam int NBANDS     = 21;
  localparam int BAND_BITS  = $clog2(NBANDS + 1);

  typedef logic signed [VAL_BITS-1:0]   val_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [INDEX_BITS-1:0] index_t;
  typedef logic        [CNT_BITS-1:0]   count_t;
  typedef logic        [6:0]            ascii_t;
  typedef logic        [2:0]            reg_idx_t;

  localparam reg_idx_t REG_MAX_ITER    = 3'd0;
  localparam reg_idx_t REG_STEP_REAL   = 3'd1;
  localparam reg_idx_t REG_STEP_IMAG   = 3'd2;
  localparam reg_idx_t REG_OFFSET_REAL = 3'd3;
  localparam reg_idx_t REG_OFFSET_IMAG = 3'd4;

  localparam count_t      MAX_ITER_RST  = 16'd1000;
  localparam logic [30:0] STEP_REAL_RST = 31'd8036990;
  localparam logic [30:0] STEP_IMAG_RST = 31'd15606713;

  localparam val_t  VMAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam val_t  VMIN = {1'b1, {(VAL_BITS-1){1'b0}}};
  localparam prod_t FOUR = prod_t'(1) <<< (FRAC_BITS + 2);

  localparam count_t BAND_START [NBANDS] = '{
    16'd2,  16'd4,  16'd6,  16'd8,  16'd10, 16'd11, 16'd13, 16'd15, 16'd17, 16'd19, 16'd21,
    16'd22, 16'd24, 16'd26, 16'd28, 16'd30, 16'd32, 16'd33, 16'd35, 16'd37, 16'd39
  };

  // . , ~ - = _ ' ^ " * ! [ o g a O Q H @ G # space
  localparam ascii_t SHADE [NBANDS+1] = '{
    7'h2E, 7'h2C, 7'h7E, 7'h2D, 7'h3D, 7'h5F, 7'h27, 7'h5E, 7'h22, 7'h2A, 7'h21,
    7'h5B, 7'h6F, 7'h67, 7'h61, 7'h4F, 7'h51, 7'h48, 7'h40, 7'h47, 7'h23, 7'h20
  };

  function automatic val_t sat_val(input prod_t v);
    val_t r;
    if (v > prod_t'(VMAX)) begin
      r = VMAX;
    end else if (v < prod_t'(VMIN)) begin
      r = VMIN;
    end else begin
      r = v[VAL_BITS-1:0];
    end
    return r;
  endfunction

  function automatic ascii_t shade_of(input count_t c);
    logic [BAND_BITS-1:0] band;
    band = '0;
    for (int i = 0; i < NBANDS; i++) begin
      if (c >= BAND_START[i]) begin
        band = band + 1'b1;
      end
    end
    return SHADE[band];
  endfunction

endpackage

[src/mandelbrot_escape_time_ascii_top.sv]
// Channel  | Dir | Signals                      | Payload
// in_      | in  | tvalid tready tdata[31:0]    | column, row
// out_     | out | tvalid tready tdata[23:0]    | iteration_count, inside_set, shade_symbol
// cfg_     | in  | valid ready index[2:0] data  | register write
// One pixel at a time through a single shared 32x32 multiplier.
// Each pixel is mapped to c, then each iteration runs x*x, y*y, x*y and update in turn.
// rst_n is synchronous; it restores the register defaults and empties the output.
// A result waiting on out_tready holds the block; cfg_ready is high only when idle.
module mandelbrot_escape_time_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] column, [31:16] row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] iteration_count, [16] inside_set, [23:17] shade_symbol
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAPR, S_MAPI, S_CI, S_TEST, S_XX, S_YY, S_XY, S_DONE
  } state_t;

  state_t state_r;

  met_pkg::count_t      max_iter_r;
  logic [30:0]          step_real_r;
  logic [30:0]          step_imag_r;
  logic signed [31:0]   offset_real_r;
  logic signed [31:0]   offset_imag_r;

  met_pkg::index_t col_r, row_r;
  met_pkg::val_t   cr_r, ci_r, x_r, y_r, xx_r, yy_r;
  met_pkg::count_t count_r;
  logic            esc_r;

  met_pkg::val_t   mul_a, mul_b;
  met_pkg::prod_t  prod_nxt, prod_r;
  met_pkg::prod_t  mag2, xy2;

  logic            out_tvalid_r;
  met_pkg::count_t out_count_r;
  logic            out_inside_r;
  met_pkg::ascii_t out_shade_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !out_tvalid_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_shade_r, out_inside_r, out_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r    <= met_pkg::MAX_ITER_RST;
      step_real_r   <= met_pkg::STEP_REAL_RST;
      step_imag_r   <= met_pkg::STEP_IMAG_RST;
      offset_real_r <= '0;
      offset_imag_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        met_pkg::REG_MAX_ITER:    max_iter_r    <= cfg_data[15:0];
        met_pkg::REG_STEP_REAL:   step_real_r   <= cfg_data[30:0];
        met_pkg::REG_STEP_IMAG:   step_imag_r   <= cfg_data[30:0];
        met_pkg::REG_OFFSET_REAL: offset_real_r <= cfg_data;
        met_pkg::REG_OFFSET_IMAG: offset_imag_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_MAPR: begin
        mul_a = met_pkg::val_t'(col_r);
        mul_b = met_pkg::val_t'({1'b0, step_real_r});
      end
      S_MAPI: begin
        mul_a = met_pkg::val_t'(row_r);
        mul_b = met_pkg::val_t'({1'b0, step_imag_r});
      end
      S_TEST: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_XX: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
  end

  assign prod_nxt = met_pkg::prod_t'(mul_a) * met_pkg::prod_t'(mul_b);
  assign mag2     = met_pkg::prod_t'(xx_r) + met_pkg::prod_t'(yy_r);
  assign xy2      = prod_r >>> (met_pkg::FRAC_BITS - 1);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      count_r      <= '0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            col_r   <= in_tdata[15:0];
            row_r   <= in_tdata[31:16];
            count_r <= '0;
            state_r <= S_MAPR;
          end
        end
        S_MAPR: state_r <= S_MAPI;
        S_MAPI: begin
          cr_r    <= met_pkg::sat_val(prod_r + met_pkg::prod_t'(offset_real_r));
          state_r <= S_CI;
        end
        S_CI: begin
          ci_r    <= met_pkg::sat_val(prod_r + met_pkg::prod_t'(offset_imag_r));
          x_r     <= '0;
          y_r     <= '0;
          state_r <= S_TEST;
        end
        S_TEST: begin
          if (count_r >= max_iter_r) begin
            esc_r   <= 1'b0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_XX;
          end
        end
        S_XX: begin
          xx_r    <= met_pkg::sat_val(prod_r >>> met_pkg::FRAC_BITS);
          state_r <= S_YY;
        end
        S_YY: begin
          yy_r    <= met_pkg::sat_val(prod_r >>> met_pkg::FRAC_BITS);
          state_r <= S_XY;
        end
        S_XY: begin
          if (mag2 > met_pkg::FOUR) begin
            esc_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            x_r     <= met_pkg::sat_val(met_pkg::prod_t'(xx_r) - met_pkg::prod_t'(yy_r)
                                        + met_pkg::prod_t'(cr_r));
            y_r     <= met_pkg::sat_val(met_pkg::prod_t'(met_pkg::sat_val(xy2))
                                        + met_pkg::prod_t'(ci_r));
            count_r <= count_r + 1'b1;
            state_r <= S_TEST;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_count_r  <= count_r;
            out_inside_r <= !esc_r;
            out_shade_r  <= met_pkg::shade_of(count_r);
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_inside_r |-> out_count_r == max_iter_r)
    else $error("inside result with count other than the limit");

  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_inside_r |-> out_count_r < max_iter_r)
    else $error("escaped result with count at or past the limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> count_r <= max_iter_r)
    else $error("iteration count past the limit");

endmodule

[verif/met_escape_checker.sv]
`timescale 1ns / 100ps

module met_escape_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          n_fail,
  output int          n_pending,
  output int          n_pixels,
  output int          n_results,
  output int          n_inside,
  output int          n_writes,
  output int          deepest,
  output int          n_shades
);

  import met_pkg::*;

  localparam longint VAL_HI    = (longint'(1) <<< (VAL_BITS - 1)) - 1;
  localparam longint VAL_LO    = -VAL_HI - 1;
  localparam longint ESCAPE_R2 = longint'(4) <<< FRAC_BITS;
  localparam int     NUM_EDGES = 21;
  localparam int unsigned BAND_EDGES [NUM_EDGES] = '{
    2, 4, 6, 8, 10, 11, 13, 15, 17, 19, 21, 22, 24, 26, 28, 30, 32, 33, 35, 37, 39
  };
  localparam string SHADE_RAMP = ".,~-=_'^\"*![ogaOQH@G# ";

  typedef struct {
    count_t iters;
    logic   in_set;
    ascii_t glyph;
  } pixel_result_t;

  count_t          lim_iter;
  logic [30:0]     step_re;
  logic [30:0]     step_im;
  logic signed [31:0] off_re;
  logic signed [31:0] off_im;

  pixel_result_t   awaited_pixels [$];
  logic [127:0]    glyph_seen;
  int              fails, pixels, results, inside_cnt, writes, peak;

  function automatic longint clamp_val(input longint v);
    if (v > VAL_HI) return VAL_HI;
    if (v < VAL_LO) return VAL_LO;
    return v;
  endfunction

  // floor(a*b / 2^sh), clamped to the value range
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    return clamp_val((a * b) >>> sh);
  endfunction

  function automatic pixel_result_t escape_time(input index_t col, input index_t row);
    longint        cr, ci, x, y, xx, yy, xy2;
    int unsigned   iters;
    bit            escaped;
    int            band;
    pixel_result_t r;
    cr = clamp_val(longint'(col) * longint'({1'b0, step_re}) + longint'(off_re));
    ci = clamp_val(longint'(row) * longint'({1'b0, step_im}) + longint'(off_im));
    x = 0;
    y = 0;
    iters = 0;
    escaped = 1'b0;
    while (iters < lim_iter) begin
      xx = fx_mul(x, x, FRAC_BITS);
      yy = fx_mul(y, y, FRAC_BITS);
      if (xx + yy > ESCAPE_R2) begin
        escaped = 1'b1;
        break;
      end
      xy2 = fx_mul(x, y, FRAC_BITS - 1);
      x = clamp_val(xx - yy + cr);
      y = clamp_val(xy2 + ci);
      iters++;
    end
    band = 0;
    for (int k = 0; k < NUM_EDGES; k++) begin
      if (iters >= BAND_EDGES[k]) band++;
    end
    r.iters  = count_t'(iters);
    r.in_set = !escaped;
    r.glyph  = ascii_t'(SHADE_RAMP[band]);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_result_t want, got;
    if (!rst_n) begin
      lim_iter   = MAX_ITER_RST;
      step_re    = STEP_REAL_RST;
      step_im    = STEP_IMAG_RST;
      off_re     = '0;
      off_im     = '0;
      awaited_pixels.delete();
      glyph_seen = '0;
      fails      = 0;
      pixels     = 0;
      results    = 0;
      inside_cnt = 0;
      writes     = 0;
      peak       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        writes++;
        case (reg_idx_t'(cfg_index))
          REG_MAX_ITER:    lim_iter = cfg_data[15:0];
          REG_STEP_REAL:   step_re  = cfg_data[30:0];
          REG_STEP_IMAG:   step_im  = cfg_data[30:0];
          REG_OFFSET_REAL: off_re   = cfg_data;
          REG_OFFSET_IMAG: off_im   = cfg_data;
          default: ;
        endcase
      end
      // results first, so a result can never match a pixel taken in the same transfer cycle
      if (out_tvalid && out_tready) begin
        got.iters  = out_tdata[15:0];
        got.in_set = out_tdata[16];
        got.glyph  = out_tdata[23:17];
        results++;
        if (got.in_set) inside_cnt++;
        if (int'(got.iters) > peak) peak = int'(got.iters);
        glyph_seen[got.glyph] = 1'b1;
        if (awaited_pixels.size() == 0) begin
          $error("unexpected result: iteration_count %0d, inside_set %0d, shade_symbol %0d",
                 got.iters, got.in_set, got.glyph);
          fails++;
        end else begin
          want = awaited_pixels.pop_front();
          if (got.iters !== want.iters) begin
            $error("iteration_count: expected %0d, got %0d", want.iters, got.iters);
            fails++;
          end
          if (got.in_set !== want.in_set) begin
            $error("inside_set: expected %0d, got %0d", want.in_set, got.in_set);
            fails++;
          end
          if (got.glyph !== want.glyph) begin
            $error("shade_symbol: expected %0d, got %0d", want.glyph, got.glyph);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_pixels.push_back(escape_time(in_tdata[15:0], in_tdata[31:16]));
        pixels++;
      end
    end
    n_fail    <= fails;
    n_pending <= awaited_pixels.size();
    n_pixels  <= pixels;
    n_results <= results;
    n_inside  <= inside_cnt;
    n_writes  <= writes;
    deepest   <= peak;
    n_shades  <= $countones(glyph_seen);
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  import met_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int REG_SPAN    = 1 << $bits(reg_idx_t);
  localparam int FX_ONE      = 1 << FRAC_BITS;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] column, [31:16] row
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [15:0] iteration_count, [16] inside_set, [23:17] shade_symbol
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int   n_fail, n_pending, n_pixels, n_results, n_inside, n_writes, deepest, n_shades;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  mandelbrot_escape_time_ascii_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  met_escape_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_fail     (n_fail),
    .n_pending  (n_pending),
    .n_pixels   (n_pixels),
    .n_results  (n_results),
    .n_inside   (n_inside),
    .n_writes   (n_writes),
    .deepest    (deepest),
    .n_shades   (n_shades)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_pixel(input int col, input int row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {index_t'(row), index_t'(col)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_pixel(input bit wild);
    if (!wild && $urandom_range(99) < 85) begin
      send_pixel(int'($urandom_range(0, 160)) - 100, int'($urandom_range(0, 120)) - 60);
    end else begin
      send_pixel(int'($urandom), int'($urandom));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain: every pending result back, then idle clocks before the next step
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    int mi;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAX_ITER;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: corners of the index range and a few points near the set
    send_pixel(0, 0);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
    send_pixel(32767, -32768);
    send_pixel(-32768, 32767);
    send_pixel(-60, 10);
    send_pixel(-20, -12);
    send_pixel(5, 3);
    settle();

    // zero iteration limit; writes to unmapped indexes must be dropped
    write_reg(REG_MAX_ITER, 32'hABCD_0000);
    for (int k = int'(REG_OFFSET_IMAG) + 1; k < REG_SPAN; k++) begin
      write_reg(reg_idx_t'(k), $urandom);
    end
    end_writes();
    send_pixel(0, 0);
    send_pixel(-32768, 32767);
    settle();

    // largest limit, largest real step, zero imaginary step, offsets at the format bounds: c saturates
    write_reg(REG_MAX_ITER, 32'hFFFF_FFFF);
    write_reg(REG_STEP_REAL, 32'hFFFF_FFFF);
    write_reg(REG_STEP_IMAG, 32'h0000_0000);
    write_reg(REG_OFFSET_REAL, 32'h8000_0000);
    write_reg(REG_OFFSET_IMAG, 32'h7FFF_FFFF);
    end_writes();
    send_pixel(0, 0);
    send_pixel(32767, 0);
    send_pixel(-32768, 1);
    settle();

    // c = 0 never escapes: full-length run to the largest count
    write_reg(REG_STEP_REAL, 32'h8000_0000);
    write_reg(REG_OFFSET_REAL, 32'h0000_0000);
    write_reg(REG_OFFSET_IMAG, 32'h0000_0000);
    end_writes();
    send_pixel(1234, -77);
    settle();

    // unit steps: exact boundary points, limit of one
    write_reg(REG_MAX_ITER, 32'd1);
    write_reg(REG_STEP_REAL, 32'(FX_ONE));
    write_reg(REG_STEP_IMAG, 32'(FX_ONE));
    end_writes();
    send_pixel(-2, 0);
    settle();
    write_reg(REG_MAX_ITER, 32'd50);
    end_writes();
    send_pixel(-2, 0);
    send_pixel(2, 0);
    send_pixel(0, 1);
    send_pixel(0, -2);
    send_pixel(1, 1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        mi = $urandom_range(1, 400);
        write_reg(REG_MAX_ITER, {16'($urandom), 16'(mi)});
        write_reg(REG_STEP_REAL, $urandom);
        write_reg(REG_STEP_IMAG, $urandom);
        write_reg(REG_OFFSET_REAL, $urandom);
        write_reg(REG_OFFSET_IMAG, $urandom);
      end else begin
        mi = (p == 5) ? $urandom_range(200, 400) : $urandom_range(20, 70);
        write_reg(REG_MAX_ITER, {16'($urandom), 16'(mi)});
        write_reg(REG_STEP_REAL,
                  {1'($urandom), 31'($urandom_range(FX_ONE / 64, FX_ONE / 20))});
        write_reg(REG_STEP_IMAG,
                  {1'($urandom), 31'($urandom_range(FX_ONE / 64, FX_ONE / 20))});
        write_reg(REG_OFFSET_REAL,
                  32'(-(FX_ONE / 2) - FX_ONE / 4 + int'($urandom_range(0, FX_ONE / 2))));
        write_reg(REG_OFFSET_IMAG, 32'(int'($urandom_range(0, FX_ONE / 2)) - FX_ONE / 4));
        write_reg(reg_idx_t'($urandom_range(int'(REG_OFFSET_IMAG) + 1, REG_SPAN - 1)),
                  $urandom);
      end
      end_writes();
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 64; end
        default: begin tx_idle_pct = 6; rx_stall_pct <= 6; end
      endcase
      if (p == 0) hold_arm <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_pixel(p == 3);
      end
      settle();
    end

    $display("%0d pixels under %0d register writes; %0d results, %0d inside the set",
             n_pixels, n_writes, n_results, n_inside);
    $display("deepest count %0d, %0d distinct shade symbols, all four idling patterns",
             deepest, n_shades);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    int ticks;
    ticks = 0;
    while (ticks < CYCLE_LIMIT) begin
      @(posedge clk);
      ticks++;
    end
    $error("timeout after %0d cycles, %0d results pending", CYCLE_LIMIT, n_pending);
    $display("tb: failure");
    $finish;
  end

endmodule

[mandelbrot_escape_time_ascii_top.f]
src/met_pkg.sv
src/mandelbrot_escape_time_ascii_top.sv
verif/met_escape_checker.sv
verif/tb_top.sv
